// ===== hdl/dufg_pkg.sv =====
// Shared types and constants for the dual-gradient unit normal pipeline.
package dufg_pkg;

    localparam int IN_W       = 32;
    localparam int FRAC       = 14;
    localparam int OUT_W      = 16;
    localparam int SQ_W       = 2 * IN_W;
    localparam int ROOT_W     = IN_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int NORM_STEPS = $clog2(SQ_W) - 1;
    localparam int NUM_W      = IN_W + FRAC + 1;
    localparam int DIV_STEPS  = FRAC + 1;
    localparam int LAT        = 2 + NORM_STEPS + ROOT_W + 1 + DIV_STEPS;

    typedef struct packed {
        logic signed [IN_W-1:0] beta_grad_x;
        logic signed [IN_W-1:0] beta_grad_y;
        logic signed [IN_W-1:0] beta_grad_z;
        logic signed [IN_W-1:0] gamma_grad_x;
        logic signed [IN_W-1:0] gamma_grad_y;
        logic signed [IN_W-1:0] gamma_grad_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] first_normal_x;
        logic signed [OUT_W-1:0] first_normal_y;
        logic signed [OUT_W-1:0] first_normal_z;
        logic signed [OUT_W-1:0] second_normal_x;
        logic signed [OUT_W-1:0] second_normal_y;
        logic signed [OUT_W-1:0] second_normal_z;
        logic                    first_degenerate;
        logic                    second_degenerate;
    } t_out;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
        logic             degen;
    } t_vec_res;

endpackage

// ===== hdl/dufg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module dufg_div import dufg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic [FRAC:0]     o_quo
);

    logic [NUM_W-1:0]  r_rem [DIV_STEPS];
    logic [ROOT_W-1:0] r_den [DIV_STEPS];
    logic [FRAC:0]     r_quo [DIV_STEPS];

    genvar j;
    for (j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int B = FRAC - j;
        logic [NUM_W-1:0]  rem_i;
        logic [ROOT_W-1:0] den_i;
        logic [FRAC:0]     quo_i;
        logic [NUM_W-1:0]  d;

        if (j == 0) begin : g_first
            assign rem_i = i_num;
            assign den_i = i_den;
            assign quo_i = '0;
        end else begin : g_next
            assign rem_i = r_rem[j-1];
            assign den_i = r_den[j-1];
            assign quo_i = r_quo[j-1];
        end

        assign d = NUM_W'(den_i) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j] <= den_i;
                if (rem_i >= d) begin
                    r_rem[j] <= rem_i - d;
                    r_quo[j] <= {quo_i[FRAC-1:0], 1'b1};
                end else begin
                    r_rem[j] <= rem_i;
                    r_quo[j] <= {quo_i[FRAC-1:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

// ===== hdl/dufg_vec_pipe.sv =====
// One vector lane: square, sum, normalize shift, square root, divide, format.
module dufg_vec_pipe import dufg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SQ_W-1:0] i_thr,
    input  logic [IN_W-1:0] i_x,
    input  logic [IN_W-1:0] i_y,
    input  logic [IN_W-1:0] i_z,
    output t_vec_res        o_res
);

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_side;

    localparam logic [FRAC:0] ONE = (FRAC+1)'(1) << FRAC;

    // square stage
    logic [IN_W-1:0]        v      [3];
    logic signed [SQ_W-1:0] sq     [3];
    logic [IN_W-1:0]        mag    [3];
    logic [SQ_W-1:0]        r_sq   [3];
    logic [IN_W-1:0]        r_mag0 [3];
    logic [2:0]             r_neg0;

    assign v[0] = i_x;
    assign v[1] = i_y;
    assign v[2] = i_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sq[c]  = $signed(v[c]) * $signed(v[c]);
            mag[c] = v[c][IN_W-1] ? (~v[c] + 1'b1) : v[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sq[c]   <= sq[c];
                r_mag0[c] <= mag[c];
                r_neg0[c] <= v[c][IN_W-1];
            end
        end
    end

    // sum stage
    logic [SQ_W-1:0] r_s;
    logic [IN_W-1:0] r_mag1 [3];
    logic [2:0]      r_neg1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= r_sq[0] + r_sq[1] + r_sq[2];
            r_mag1 <= r_mag0;
            r_neg1 <= r_neg0;
        end
    end

    // normalize: shift by halving even amounts until bit 63 or 62 is set
    logic [SQ_W-1:0] r_nt [NORM_STEPS];
    logic [IN_W-1:0] r_nm [NORM_STEPS][3];
    t_side           r_ns [NORM_STEPS];

    genvar j;
    for (j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = SQ_W >> (j + 1);
        localparam int HS = SH / 2;
        logic [SQ_W-1:0] t_i;
        logic [IN_W-1:0] m_i [3];
        t_side           s_i;

        if (j == 0) begin : g_first
            assign t_i = r_s;
            assign m_i = r_mag1;
            assign s_i = {r_neg1, (r_s == '0) || (r_s < i_thr)};
        end else begin : g_next
            assign t_i = r_nt[j-1];
            assign m_i = r_nm[j-1];
            assign s_i = r_ns[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ns[j] <= s_i;
                if (t_i[SQ_W-1 -: SH] == '0) begin
                    r_nt[j] <= t_i << SH;
                    for (int c = 0; c < 3; c++) r_nm[j][c] <= m_i[c] << HS;
                end else begin
                    r_nt[j] <= t_i;
                    r_nm[j] <= m_i;
                end
            end
        end
    end

    // square root, one root bit per stage
    logic [SQ_W-1:0]   r_qt   [ROOT_W];
    logic [ROOT_W-1:0] r_qr   [ROOT_W];
    logic [REM_W-1:0]  r_qrem [ROOT_W];
    logic [IN_W-1:0]   r_qm   [ROOT_W][3];
    t_side             r_qs   [ROOT_W];

    genvar i;
    for (i = 0; i < ROOT_W; i++) begin : g_sqrt
        localparam int TB = SQ_W - 1 - 2 * i;
        logic [SQ_W-1:0]   t_i;
        logic [ROOT_W-1:0] r_i;
        logic [REM_W-1:0]  rem_i;
        logic [IN_W-1:0]   m_i [3];
        t_side             s_i;
        logic [REM_W+1:0]  rs;
        logic [REM_W+1:0]  trial;

        if (i == 0) begin : g_first
            assign t_i   = r_nt[NORM_STEPS-1];
            assign r_i   = '0;
            assign rem_i = '0;
            assign m_i   = r_nm[NORM_STEPS-1];
            assign s_i   = r_ns[NORM_STEPS-1];
        end else begin : g_next
            assign t_i   = r_qt[i-1];
            assign r_i   = r_qr[i-1];
            assign rem_i = r_qrem[i-1];
            assign m_i   = r_qm[i-1];
            assign s_i   = r_qs[i-1];
        end

        assign rs    = {rem_i, t_i[TB -: 2]};
        assign trial = (REM_W+2)'({r_i, 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qt[i] <= t_i;
                r_qm[i] <= m_i;
                r_qs[i] <= s_i;
                if (rs >= trial) begin
                    r_qrem[i] <= REM_W'(rs - trial);
                    r_qr[i]   <= {r_i[ROOT_W-2:0], 1'b1};
                end else begin
                    r_qrem[i] <= REM_W'(rs);
                    r_qr[i]   <= {r_i[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // numerator with half-divisor rounding term
    logic [NUM_W-1:0]  r_num [3];
    logic [ROOT_W-1:0] r_den;
    t_side             r_ds;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= (NUM_W'(r_qm[ROOT_W-1][c]) << FRAC)
                          + NUM_W'(r_qr[ROOT_W-1] >> 1);
            end
            r_den <= r_qr[ROOT_W-1];
            r_ds  <= r_qs[ROOT_W-1];
        end
    end

    logic [FRAC:0] quo [3];

    for (i = 0; i < 3; i++) begin : g_div
        dufg_div u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (r_num[i]),
            .i_den (r_den),
            .o_quo (quo[i])
        );
    end

    t_side r_dsd [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsd[0] <= r_ds;
            for (int k = 1; k < DIV_STEPS; k++) r_dsd[k] <= r_dsd[k-1];
        end
    end

    // clamp, apply negated sign, zero degenerate vectors
    logic [FRAC:0]    qc  [3];
    logic [OUT_W-1:0] val [3];
    t_side            fs;

    always_comb begin
        fs = r_dsd[DIV_STEPS-1];
        for (int c = 0; c < 3; c++) begin
            qc[c]  = (quo[c] > ONE) ? ONE : quo[c];
            val[c] = fs.neg[c] ? OUT_W'(qc[c]) : (OUT_W'(0) - OUT_W'(qc[c]));
            if (fs.degen) val[c] = '0;
        end
        o_res.x     = val[0];
        o_res.y     = val[1];
        o_res.z     = val[2];
        o_res.degen = fs.degen;
    end

endmodule

// ===== hdl/dual_unit_normal_from_gradients.sv =====
// Top level: two-lane gradient-to-unit-normal pipeline with threshold register.
// Each transaction carries two signed Q16.16 gradients; the result gives each
// negated unit vector in Q1.14 (components within +/-16384) and a degenerate
// flag that is set, with the normal zeroed, when the squared length is zero or
// below min_norm_squared (Q32.32, reset value 1). The pipeline accepts one
// transaction per cycle while the output is not stalled and returns results in
// order through one squaring stage, one sum stage, five normalize-shift stages,
// 32 square-root stages (one root bit each), one numerator stage, 15 divider
// stages (one quotient bit each) and the output register. A stall on the output
// freezes the whole pipeline. Threshold writes are taken at any time but must
// only be issued while the pipeline is empty.
module dual_unit_normal_from_gradients import dufg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in             i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out            o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [SQ_W-1:0] i_cfg_data
);

    logic            en;
    logic [SQ_W-1:0] r_thr;
    logic [LAT-1:0]  r_vld;
    logic            r_out_valid;
    t_out            r_out;
    t_vec_res        res1;
    t_vec_res        res2;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= SQ_W'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    dufg_vec_pipe u_first (
        .i_clk (i_clk),
        .i_en  (en),
        .i_thr (r_thr),
        .i_x   (i_in.beta_grad_x),
        .i_y   (i_in.beta_grad_y),
        .i_z   (i_in.beta_grad_z),
        .o_res (res1)
    );

    dufg_vec_pipe u_second (
        .i_clk (i_clk),
        .i_en  (en),
        .i_thr (r_thr),
        .i_x   (i_in.gamma_grad_x),
        .i_y   (i_in.gamma_grad_y),
        .i_z   (i_in.gamma_grad_z),
        .o_res (res2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[LAT-2:0], i_in_valid};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.first_normal_x    <= res1.x;
            r_out.first_normal_y    <= res1.y;
            r_out.first_normal_z    <= res1.z;
            r_out.second_normal_x   <= res2.x;
            r_out.second_normal_y   <= res2.y;
            r_out.second_normal_z   <= res2.z;
            r_out.first_degenerate  <= res1.degen;
            r_out.second_degenerate <= res2.degen;
        end
    end

`ifndef SYNTHESIS
    a_first_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.first_degenerate) |->
        (o_out.first_normal_x == '0 && o_out.first_normal_y == '0 &&
         o_out.first_normal_z == '0))
        else $error("degenerate first normal not zero");

    a_second_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.second_degenerate) |->
        (o_out.second_normal_x == '0 && o_out.second_normal_y == '0 &&
         o_out.second_normal_z == '0))
        else $error("degenerate second normal not zero");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ($signed(o_out.first_normal_x) <= 16384 &&
         $signed(o_out.first_normal_x) >= -16384 &&
         $signed(o_out.second_normal_x) <= 16384 &&
         $signed(o_out.second_normal_x) >= -16384))
        else $error("normal component outside unit range");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== dv/tb_dual_unit_normal_from_gradients.sv =====
// Testbench for the dual-gradient unit normal pipeline: directed and random checks.
`timescale 1ns / 100ps

module tb_dual_unit_normal_from_gradients import dufg_pkg::*; ();

    localparam int PIPE_DRAIN = 80;
    localparam int STALL_LIMIT = 20000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in             i_in;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out            o_out;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [SQ_W-1:0] i_cfg_data;

    dual_unit_normal_from_gradients dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    logic [63:0] min_norm_sq;
    t_out        normal_queue[$];
    int          err_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // integer square root of a 64-bit value
    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_vec_res unit_normal(input logic [IN_W-1:0] cx,
                                             input logic [IN_W-1:0] cy,
                                             input logic [IN_W-1:0] cz);
        logic [63:0] mag[3];
        logic        neg[3];
        logic [IN_W-1:0] comp[3];
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] len;
        logic [63:0] q;
        logic [OUT_W-1:0] r[3];
        int          k;
        t_vec_res    res;
        comp[0] = cx;
        comp[1] = cy;
        comp[2] = cz;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = comp[i][IN_W-1];
            mag[i] = neg[i] ? 64'(-{32'd0, comp[i]} & 64'hFFFF_FFFF) : 64'(comp[i]);
            if (neg[i]) mag[i] = (64'hFFFF_FFFF - 64'(comp[i])) + 1;
            s = s + mag[i] * mag[i];
        end
        if (s == 0 || s < min_norm_sq) begin
            res = '0;
            res.degen = 1'b1;
            return res;
        end
        t = s;
        k = 0;
        while ((t >> 62) == 0) begin
            t = t << 2;
            k++;
        end
        len = root64(t);
        for (int i = 0; i < 3; i++) begin
            q = (((mag[i] << k) << FRAC) + (len >> 1)) / len;
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
            r[i] = neg[i] ? q[OUT_W-1:0] : OUT_W'(-q);
        end
        res.x = r[0];
        res.y = r[1];
        res.z = r[2];
        res.degen = 1'b0;
        return res;
    endfunction

    function automatic t_out predict_normals(input t_in g);
        t_vec_res a;
        t_vec_res b;
        t_out     o;
        a = unit_normal(g.beta_grad_x, g.beta_grad_y, g.beta_grad_z);
        b = unit_normal(g.gamma_grad_x, g.gamma_grad_y, g.gamma_grad_z);
        o.first_normal_x = a.x;
        o.first_normal_y = a.y;
        o.first_normal_z = a.z;
        o.second_normal_x = b.x;
        o.second_normal_y = b.y;
        o.second_normal_z = b.z;
        o.first_degenerate = a.degen;
        o.second_degenerate = b.degen;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_v);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
        err_count++;
    endtask

    // valid stays high between back-to-back transactions; stop_sending drops it
    task automatic send_gradients(input t_in g);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= g;
        normal_queue.push_back(predict_normals(g));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [IN_W-1:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return IN_W'($signed($urandom_range(200)) - 100);
            2: return IN_W'($signed($urandom_range(2000000)) - 1000000);
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 0;
        endcase
    endfunction

    function automatic t_in rand_gradients();
        t_in g;
        g.beta_grad_x = rand_comp();
        g.beta_grad_y = rand_comp();
        g.beta_grad_z = rand_comp();
        g.gamma_grad_x = rand_comp();
        g.gamma_grad_y = rand_comp();
        g.gamma_grad_z = rand_comp();
        return g;
    endfunction

    // only while the pipeline is empty
    task automatic write_threshold(input logic [63:0] v);
        stop_sending();
        while (normal_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        min_norm_sq = v;
    endtask

    task automatic test_directed();
        t_in g;
        logic [IN_W-1:0] pats[8];
        pats = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
        foreach (pats[i]) begin
            g.beta_grad_x = pats[i];
            g.beta_grad_y = pats[(i + 3) % 8];
            g.beta_grad_z = pats[(i + 5) % 8];
            g.gamma_grad_x = pats[(i + 1) % 8];
            g.gamma_grad_y = 0;
            g.gamma_grad_z = pats[i];
            send_gradients(g);
        end
        send_gradients('0);
        send_gradients('1);
        send_gradients({6{32'h8000_0000}});
        send_gradients({6{32'h7FFF_FFFF}});
    endtask

    task automatic test_threshold_zero();
        write_threshold(64'd0);
        send_gradients('0);
        send_gradients({32'd1, 64'd0, 32'd0, 32'hFFFF_FFFF, 32'd0});
        for (int i = 0; i < 8; i++) send_gradients(rand_gradients());
    endtask

    task automatic test_threshold_max();
        write_threshold(64'hFFFF_FFFF_FFFF_FFFF);
        send_gradients({6{32'h8000_0000}});
        for (int i = 0; i < 8; i++) send_gradients(rand_gradients());
    endtask

    task automatic test_random(input int n, input int snd, input int rcv);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        for (int i = 0; i < n; i++) send_gradients(rand_gradients());
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 100; i++) send_gradients(rand_gradients());
    endtask

    // output side: stalls and long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out exp_o;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (normal_queue.size() == 0) begin
                report_mismatch("unexpected transaction", 16'h0, 16'h0);
            end else begin
                exp_o = normal_queue.pop_front();
                if (o_out.first_normal_x !== exp_o.first_normal_x)
                    report_mismatch("first_normal_x", o_out.first_normal_x, exp_o.first_normal_x);
                if (o_out.first_normal_y !== exp_o.first_normal_y)
                    report_mismatch("first_normal_y", o_out.first_normal_y, exp_o.first_normal_y);
                if (o_out.first_normal_z !== exp_o.first_normal_z)
                    report_mismatch("first_normal_z", o_out.first_normal_z, exp_o.first_normal_z);
                if (o_out.second_normal_x !== exp_o.second_normal_x)
                    report_mismatch("second_normal_x", o_out.second_normal_x,
                                    exp_o.second_normal_x);
                if (o_out.second_normal_y !== exp_o.second_normal_y)
                    report_mismatch("second_normal_y", o_out.second_normal_y,
                                    exp_o.second_normal_y);
                if (o_out.second_normal_z !== exp_o.second_normal_z)
                    report_mismatch("second_normal_z", o_out.second_normal_z,
                                    exp_o.second_normal_z);
                if (o_out.first_degenerate !== exp_o.first_degenerate)
                    report_mismatch("first_degenerate", 16'(o_out.first_degenerate),
                                    16'(exp_o.first_degenerate));
                if (o_out.second_degenerate !== exp_o.second_degenerate)
                    report_mismatch("second_degenerate", 16'(o_out.second_degenerate),
                                    16'(exp_o.second_degenerate));
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        min_norm_sq = 64'd1;
        err_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_threshold_zero();
        test_threshold_max();
        write_threshold(64'h0000_0001_0000_0000);
        test_random(120, 0, 0);
        write_threshold({32'd0, $urandom});
        test_random(120, 63, 0);
        write_threshold({$urandom_range(3), $urandom});
        test_random(120, 0, 63);
        write_threshold(64'd1);
        test_random(120, 18, 18);
        test_backpressure();
        stop_sending();

        while (normal_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
